// File: design/at_command_name_matcher_macros.svh
// ---------------------------------------------------------------------------
// AT command name matcher: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_NAME_MATCHER_MACROS_SVH
`define AT_COMMAND_NAME_MATCHER_MACROS_SVH

// Same-cycle implication
`define ACNM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ACNM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: design/acnm_pkg.sv
// ---------------------------------------------------------------------------
// AT command name matcher package
// Command name table, terminator characters, status codes and result type.
// ---------------------------------------------------------------------------
`default_nettype none

package acnm_pkg;

  // Command name table: entry 0 is the empty name
  localparam int unsigned NAMED_ENTRIES = 10;
  localparam int unsigned NAME_MAX      = 8;

  localparam logic [3:0] NAME_LEN [NAMED_ENTRIES] = '{
    4'd0, 4'd4, 4'd6, 4'd3, 4'd3, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4
  };

  // +PWM1 stores five characters but only four are compared
  localparam logic [7:0] NAME_TEXT [NAMED_ENTRIES][NAME_MAX] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "R",   "S",   "T",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "S",   "L",   "E",   "E",   "P",   8'h00, 8'h00},
    '{"+",   "R",   "X",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "T",   "X",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "V",   "E",   "R",   "S",   "I",   "O",   "N"  },
    '{"+",   "P",   "B",   "0",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "P",   "D",   "0",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"+",   "P",   "W",   "M",   "1",   8'h00, 8'h00, 8'h00},
    '{"+",   "C",   "F",   "G",   8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Terminators
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_EQ = 8'h3D;
  localparam logic [7:0] CHAR_QM = 8'h3F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // One result of the matcher
  typedef struct packed {
    logic       emit;
    logic [3:0] id;
    status_e    status;
    logic [6:0] len;
  } result_t;

  // Name length of an entry; entries past the table have no name
  function automatic logic [3:0] entry_len(input int unsigned idx);
    logic [3:0] len;
    len = '0;
    if (idx < NAMED_ENTRIES) len = NAME_LEN[idx[3:0]];
    return len;
  endfunction

  // Character at a position of an entry's name
  function automatic logic [7:0] entry_char(input int unsigned idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = '0;
    if (idx < NAMED_ENTRIES) ch = NAME_TEXT[idx[3:0]][pos];
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: design/acnm_match.sv
// ---------------------------------------------------------------------------
// AT command name matcher: match step
// Next scan state and optional result for one byte against all table names.
// ---------------------------------------------------------------------------
`default_nettype none

module acnm_match #(
  parameter int unsigned MAX_SCAN      = 128,
  parameter int unsigned TABLE_ENTRIES = 10,
  parameter int unsigned CNT_W         = $clog2(MAX_SCAN + 1),
  parameter int unsigned MASK_W        = TABLE_ENTRIES - 1
) (
  input  logic [7:0]         data_byte_i,
  input  logic               line_start_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [MASK_W-1:0]  mask_i,
  input  logic               finished_i,
  output logic [CNT_W-1:0]   count_o,
  output logic [MASK_W-1:0]  mask_o,
  output logic               finished_o,
  output acnm_pkg::result_t  result_o
);

  logic [CNT_W-1:0]  cnt_eff;
  logic [MASK_W-1:0] mask_eff;
  logic              fin_eff;
  logic              is_term;
  logic              found;

  // Line start restarts the scan before the byte is looked at
  assign cnt_eff  = line_start_i ? '0 : count_i;
  assign mask_eff = line_start_i ? '1 : mask_i;
  assign fin_eff  = line_start_i ? 1'b0 : finished_i;

  assign is_term = (data_byte_i == acnm_pkg::CHAR_CR) ||
                   (data_byte_i == acnm_pkg::CHAR_EQ) ||
                   (data_byte_i == acnm_pkg::CHAR_QM);

  // Compare against every entry in parallel; lowest match wins
  always_comb begin
    count_o         = cnt_eff;
    mask_o          = mask_eff;
    finished_o      = fin_eff;
    result_o.emit   = 1'b0;
    result_o.id     = '0;
    result_o.status = acnm_pkg::ST_OK;
    result_o.len    = '0;
    found           = 1'b0;
    if (!fin_eff) begin
      if (is_term) begin
        finished_o    = 1'b1;
        result_o.emit = 1'b1;
        result_o.len  = 7'(cnt_eff);
        if (cnt_eff != '0) begin
          for (int unsigned i = 1; i < TABLE_ENTRIES; i++) begin
            if (!found && mask_eff[i-1] &&
                (CNT_W'(acnm_pkg::entry_len(i)) == cnt_eff)) begin
              found       = 1'b1;
              result_o.id = 4'(i);
            end
          end
          if (!found) result_o.status = acnm_pkg::ST_UNKNOWN;
        end
      end else begin
        for (int unsigned i = 1; i < TABLE_ENTRIES; i++) begin
          if ((cnt_eff < CNT_W'(acnm_pkg::entry_len(i))) &&
              (acnm_pkg::entry_char(i, cnt_eff[2:0]) != data_byte_i)) begin
            mask_o[i-1] = 1'b0;
          end
        end
        count_o = cnt_eff + CNT_W'(1);
        // No terminator within the scan limit
        if (count_o == CNT_W'(MAX_SCAN)) begin
          finished_o      = 1'b1;
          result_o.emit   = 1'b1;
          result_o.status = acnm_pkg::ST_OVERFLOW;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/at_command_name_matcher.sv
// A result is registered: the terminating byte passes the input register, then the result register.
// Throughput: one byte per cycle while in_stall_o is low; the byte register feeds a combinational
//   compare against all table names and the result register.
// The output register lets the next byte in while a result waits to be taken.
// Reset (async, active low): idle until a line start, empty pipeline.
// ---------------------------------------------------------------------------
// AT command name matcher
// Matches the name of a received AT command line against a fixed table.
// ---------------------------------------------------------------------------
`default_nettype none

module at_command_name_matcher #(
  parameter int unsigned MAX_SCAN      = 128,
  parameter int unsigned TABLE_ENTRIES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       line_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] command_id_o,
  output logic [1:0] status_o,
  output logic [6:0] name_length_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_SCAN + 1);
  localparam int unsigned MASK_W = TABLE_ENTRIES - 1;

  logic                 s1_valid_q, s1_valid_d;
  logic [7:0]           s1_byte_q;
  logic                 s1_start_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic                 fin_q, fin_d;
  logic                 out_valid_q, out_valid_d;
  logic [3:0]           id_q;
  acnm_pkg::status_e    status_q;
  logic [6:0]           len_q;
  acnm_pkg::result_t    res;
  logic                 in_acc;
  logic                 s1_fire;
  logic                 out_take;
  logic                 out_load;

  // Match step on the registered byte
  acnm_match #(
    .MAX_SCAN      (MAX_SCAN),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CNT_W         (CNT_W),
    .MASK_W        (MASK_W)
  ) u_match (
    .data_byte_i  (s1_byte_q),
    .line_start_i (s1_start_q),
    .count_i      (count_q),
    .mask_i       (mask_q),
    .finished_i   (fin_q),
    .count_o      (count_d),
    .mask_o       (mask_d),
    .finished_o   (fin_d),
    .result_o     (res)
  );

  // Handshake: an item without a result never waits on the output
  assign out_take    = out_valid_q & ~out_stall_i;
  assign s1_fire     = s1_valid_q & (~res.emit | ~out_valid_q | ~out_stall_i);
  assign out_load    = s1_fire & res.emit;
  assign in_stall_o  = s1_valid_q & ~s1_fire;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_acc | (s1_valid_q & ~s1_fire);
  assign out_valid_d = out_load | (out_valid_q & ~out_take);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= line_start_i;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mask_q  <= '1;
      fin_q   <= 1'b1;
    end else if (s1_fire) begin
      count_q <= count_d;
      mask_q  <= mask_d;
      fin_q   <= fin_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      id_q     <= res.id;
      status_q <= res.status;
      len_q    <= res.len;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign command_id_o  = id_q;
  assign status_o      = status_q;
  assign name_length_o = len_q;

  // Assertions
  `include "at_command_name_matcher_macros.svh"

  `ACNM_ASSERT_NXT(a_result_lands, out_load, out_valid_q, "result item not registered")
  `ACNM_ASSERT_NOW(a_scan_bound, !fin_q, count_q < CNT_W'(MAX_SCAN), "scan count past limit")
  `ACNM_ASSERT_NOW(a_overflow_fields, out_valid_q && status_q == acnm_pkg::ST_OVERFLOW,
    id_q == 4'd0 && len_q == 7'd0, "overflow result carries id or length")
  `ACNM_ASSERT_NOW(a_unknown_fields, out_valid_q && status_q == acnm_pkg::ST_UNKNOWN,
    id_q == 4'd0 && len_q != 7'd0, "unknown result has bad id or length")

endmodule

`default_nettype wire

// File: verif/at_command_name_matcher_checker.sv
// ---------------------------------------------------------------------------
// AT command name matcher: result checker
// Watches the byte and result channels, predicts the result of each command
// line from its own copy of the name table and compares every result taken.
// ---------------------------------------------------------------------------
`default_nettype none

module at_command_name_matcher_checker #(
  parameter int unsigned MAX_SCAN = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        line_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  command_id_i,
  input  logic [1:0]  status_i,
  input  logic [6:0]  name_length_i,
  output int unsigned mismatches_o,
  output int unsigned results_owed_o
);

  // Named entries 1..9; entry 0 is the empty name
  localparam int unsigned NUM_NAMED = 9;
  localparam int unsigned CMD_LEN [1:9] = '{4, 6, 3, 3, 8, 4, 4, 4, 4};
  // Right-justified text; +PWM1 only ever compares its first four characters
  localparam logic [63:0] CMD_TEXT [1:9] = '{
    "+RST", "+SLEEP", "+RX", "+TX", "+VERSION", "+PB0", "+PD0", "+PWM", "+CFG"
  };

  typedef struct packed {
    logic [3:0]        id;
    acnm_pkg::status_e status;
    logic [6:0]        len;
  } cmd_result_t;

  cmd_result_t          owed_results [$];
  logic [7:0]           name_count     = '0;
  logic [NUM_NAMED-1:0] still_matching = '1;
  logic                 line_done      = 1'b1;
  int unsigned          mismatch_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: result check: %s", $time, what);
  endtask

  // Advance the scan by one accepted item; queue a result when the line ends
  task automatic match_byte(input logic [7:0] b, input logic first);
    cmd_result_t res;
    int          e;
    int          pos;
    if (first) begin
      name_count     = '0;
      still_matching = '1;
      line_done      = 1'b0;
    end
    if (!line_done) begin
      if (b == acnm_pkg::CHAR_CR || b == acnm_pkg::CHAR_EQ || b == acnm_pkg::CHAR_QM) begin
        line_done  = 1'b1;
        res.id     = '0;
        res.status = acnm_pkg::ST_UNKNOWN;
        res.len    = name_count[6:0];
        if (name_count == 0) begin
          res.status = acnm_pkg::ST_OK;
        end else begin
          // walk down so the lowest matching entry wins
          for (e = NUM_NAMED; e >= 1; e--) begin
            if (still_matching[e-1] && CMD_LEN[e] == name_count) begin
              res.id     = 4'(e);
              res.status = acnm_pkg::ST_OK;
            end
          end
        end
        owed_results.push_back(res);
      end else begin
        for (e = 1; e <= NUM_NAMED; e++) begin
          if (name_count < CMD_LEN[e]) begin
            pos = (CMD_LEN[e] - 1 - name_count) * 8;
            if (CMD_TEXT[e][pos +: 8] != b) still_matching[e-1] = 1'b0;
          end
        end
        name_count = name_count + 8'd1;
        if (name_count >= MAX_SCAN) begin
          line_done  = 1'b1;
          res.id     = '0;
          res.status = acnm_pkg::ST_OVERFLOW;
          res.len    = '0;
          owed_results.push_back(res);
        end
      end
    end
  endtask

  // Compare a taken result with the oldest one owed
  task automatic check_result();
    cmd_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result id %0d status %0d length %0d",
                                command_id_i, status_i, name_length_i));
    end else begin
      want = owed_results.pop_front();
      if (command_id_i !== want.id)
        report_mismatch($sformatf("command_id %0d, expected %0d", command_id_i, want.id));
      if (status_i !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
      if (name_length_i !== want.len)
        report_mismatch($sformatf("name_length %0d, expected %0d", name_length_i, want.len));
    end
  endtask

  // Results are compared before the same edge's item is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_count     = '0;
      still_matching = '1;
      line_done      = 1'b1;
      owed_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) match_byte(data_byte_i, line_start_i);
    end
    results_owed_o <= owed_results.size();
    mismatches_o   <= mismatch_count;
  end

endmodule

`default_nettype wire

// File: verif/tb_at_command_name_matcher.sv
// ---------------------------------------------------------------------------
// AT command name matcher testbench
// Feeds directed and random command lines under several idle and stall
// patterns, with one long receiver hold-off; a checker judges every result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_at_command_name_matcher;

  localparam int unsigned MAX_SCAN       = 128;
  localparam int unsigned ITEM_GOAL      = 1650;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef logic [7:0] byte_q_t [$];

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        line_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  command_id_o;
  logic [1:0]  status_o;
  logic [6:0]  name_length_o;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_pending       = 1'b0;
  int unsigned name_bytes_sent    = 0;
  int unsigned quiet_cycles       = 0;

  string      cmd_names [1:9] = '{
    "+RST", "+SLEEP", "+RX", "+TX", "+VERSION", "+PB0", "+PD0", "+PWM1", "+CFG"
  };
  logic [7:0] term_chars [3] = '{acnm_pkg::CHAR_CR, acnm_pkg::CHAR_EQ, acnm_pkg::CHAR_QM};

  at_command_name_matcher #(
    .MAX_SCAN (MAX_SCAN)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .line_start_i  (line_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .command_id_o  (command_id_o),
    .status_o      (status_o),
    .name_length_o (name_length_o)
  );

  at_command_name_matcher_checker #(
    .MAX_SCAN (MAX_SCAN)
  ) result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .line_start_i   (line_start_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_id_i   (command_id_o),
    .status_i       (status_o),
    .name_length_i  (name_length_o),
    .mismatches_o   (mismatches),
    .results_owed_o (results_owed)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic is_terminator(input logic [7:0] b);
    return b == acnm_pkg::CHAR_CR || b == acnm_pkg::CHAR_EQ || b == acnm_pkg::CHAR_QM;
  endfunction

  // Offer one item, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic first);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    line_start_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send a line; bytes up to the end of the name count toward the item goal
  task automatic send_line(input byte_q_t bytes, input logic mark_start);
    logic live;
    live = mark_start;
    foreach (bytes[k]) begin
      send_item(bytes[k], mark_start && (k == 0));
      if (live) begin
        name_bytes_sent++;
        if (is_terminator(bytes[k]) || k + 1 >= MAX_SCAN) live = 1'b0;
      end
    end
  endtask

  // Mostly table names with random terminators and arguments, some damaged,
  // some empty, some noise; each call opens with a name at the scan limit
  task automatic send_random_lines(input int unsigned goal);
    byte_q_t     line;
    string       name;
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    logic [7:0]  b;
    logic        opening;
    opening = 1'b1;
    while (name_bytes_sent < goal) begin
      line.delete();
      kind    = opening ? 199 : $urandom_range(0, 199);
      opening = 1'b0;
      if (kind < 150) begin
        name = cmd_names[$urandom_range(1, 9)];
        len  = name.len();
        if (name == "+PWM1" && $urandom_range(0, 1) == 1) len = 4;
        for (pos = 0; pos < len; pos++) line.push_back(name[pos]);
        // damaged name: one byte swapped, one dropped or one added
        if (kind >= 115) begin
          case ($urandom_range(0, 2))
            0: begin
              pos = $urandom_range(0, len - 1);
              b   = 8'($urandom_range(0, 255));
              if (!is_terminator(b)) line[pos] = b;
            end
            1: void'(line.pop_back());
            default: line.push_back(8'($urandom_range(8'h21, 8'h7E)));
          endcase
        end
        line.push_back(term_chars[$urandom_range(0, 2)]);
      end else if (kind < 165) begin
        line.push_back(term_chars[$urandom_range(0, 2)]);
      end else if (kind < 195) begin
        // raw bytes, terminator optional: an open line is cut by the next start
        repeat ($urandom_range(0, 12)) line.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) line.push_back(term_chars[$urandom_range(0, 2)]);
      end else begin
        // longest legal name, or no terminator within the scan limit
        len = ($urandom_range(0, 1) == 1) ? MAX_SCAN - 1
                                          : $urandom_range(MAX_SCAN, MAX_SCAN + 4);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (is_terminator(b)) b ^= 8'h80;
          line.push_back(b);
        end
        if (len < MAX_SCAN) line.push_back(term_chars[$urandom_range(0, 2)]);
      end
      // argument bytes
      repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(0, 255)));
      send_line(line, 1'b1);
      // stray bytes with no line start
      if ($urandom_range(0, 9) == 0) begin
        line.delete();
        repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(0, 255)));
        send_line(line, 1'b0);
      end
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog: too long with nothing moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_at_command_name_matcher: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    byte_q_t line;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    line_start_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty name
    line = '{acnm_pkg::CHAR_CR};
    send_line(line, 1'b1);
    // short table name
    line = '{"+", "R", "X", acnm_pkg::CHAR_EQ};
    send_line(line, 1'b1);
    // +PWM matches the four-character entry
    line = '{"+", "P", "W", "M", acnm_pkg::CHAR_QM};
    send_line(line, 1'b1);
    // byte while idle, ignored
    line = '{"A"};
    send_line(line, 1'b0);
    // line cut by a new start that is itself an empty name
    line = '{"+", "R"};
    send_line(line, 1'b1);
    line = '{acnm_pkg::CHAR_CR};
    send_line(line, 1'b1);
    // extreme byte values, unknown name
    line = '{8'hFF, 8'h00, acnm_pkg::CHAR_CR};
    send_line(line, 1'b1);
    // full +PWM1 is one byte too long
    line = '{"+", "P", "W", "M", "1", acnm_pkg::CHAR_EQ};
    send_line(line, 1'b1);

    // receiver holds off while one-byte lines pile up
    hold_pending = 1'b1;
    repeat (12) begin
      line = '{acnm_pkg::CHAR_EQ};
      send_line(line, 1'b1);
    end

    send_random_lines(ITEM_GOAL / 4);
    sender_idle_pct = 75;
    send_random_lines(ITEM_GOAL / 2);
    sender_idle_pct    = 0;
    receiver_stall_pct = 75;
    send_random_lines(ITEM_GOAL * 3 / 4);
    sender_idle_pct    = 6;
    receiver_stall_pct = 6;
    send_random_lines(ITEM_GOAL);

    in_valid_i <= 1'b0;
    while (results_owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_at_command_name_matcher: PASS");
    end else begin
      $display("tb_at_command_name_matcher: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
